/* design/fnmf_pkg.sv */
`default_nettype none

package fnmf_pkg;

    localparam int PIX_W  = 8;    // pixel width
    localparam int CFG_W  = 11;   // size register width
    localparam int APB_AW = 3;    // two registers at byte 0 and 4
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd480;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd640;

    // register index, paddr[2]
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FP_W       = 2;
    localparam int FC_W       = 3;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eof;
        logic             last;
    } t_result;

endpackage

`default_nettype wire

/* design/four_neighbour_mean_filter_unit.sv */
// Four-neighbour mean filter over a raster-order 8-bit pixel stream.
// Input stream (s_axis_*): one pixel per item, row and column are counted here.
// Output stream (m_axis_*): filtered pixels in raster order; tlast marks the
// final pixel of a frame, tuser marks the last result caused by an input item.
// Interior pixels are (up + down + left + right) >> 2; border rows and columns
// pass through. Row 0 is emitted as it arrives, row 1 emits nothing, a middle
// row emits the row above one pixel per input, and the last row emits the row
// above followed by the input pixel itself (two results per item).
// Rate: one item per clock while the output queue has room; the two line
// memories are read one column ahead at every accept. On the last row each
// item queues two results, so the input is held back to the output's pace.
// Queue: a result enters the 4-entry output queue at the accept edge and is
// visible on m_axis_tvalid in the next cycle.
// Stall: when m_axis_tready is low the queue fills; s_axis_tready drops once
// fewer than two queue entries are free.
// Reset: counters go to row 0, column 0, sizes to 480 x 640, queue empties.
// Line memories are not cleared; the first two rows of a frame fill them.
// Config (APB): frame_width at 0x0, frame_height at 0x4; write while idle.

`default_nettype none

module four_neighbour_mean_filter_unit
    import fnmf_pkg::*;
#(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // pixel in
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [PIX_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
    // pixel out
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [PIX_W-1:0]       m_axis_tdata,   // [7:0] pixel_out
    output logic                   m_axis_tlast,   // end_of_frame
    output logic                   m_axis_tuser,   // [0] last_of_run
    // config
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int DCW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
    localparam int DRW = (CFG_W > RW + 1) ? CFG_W : RW + 1;

    // config registers
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    // position of next input
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // line memories: older = two rows up, newer = row just above
    logic [PIX_W-1:0] mem_older [MAX_COLS];
    logic [PIX_W-1:0] mem_newer [MAX_COLS];

    // neighbourhood of current column
    logic [PIX_W-1:0] r_up2;    // older[c], memory read data
    logic [PIX_W-1:0] r_right;  // newer[c+1], memory read data
    logic [PIX_W-1:0] r_up1;    // newer[c]
    logic [PIX_W-1:0] r_left;   // newer[c-1] before this row's write
    logic [PIX_W-1:0] r_first;  // pixel written at column 0 of this row

    // output queue
    t_result         r_fifo [FIFO_DEPTH];
    logic [FP_W-1:0] r_wr;
    logic [FP_W-1:0] r_rd;
    logic [FC_W-1:0] r_count;
    logic [FC_W-1:0] n_count;

    logic [DCW-1:0]     w_ext;
    logic [DRW-1:0]     h_ext;
    logic [CW-1:0]      col_last;
    logic [RW-1:0]      row_last;
    logic               last_col;
    logic               last_row;
    logic               row0;
    logic               row1;
    logic               border;
    logic [CW-1:0]      col_next;
    logic [CW-1:0]      newer_addr;
    logic [RW-1:0]      row_next;
    logic [PIX_W+1:0]   sum;
    logic [PIX_W-1:0]   out_pix;
    logic [1:0]         push_n;
    t_result            ent0;
    t_result            ent1;
    logic               acc;
    logic               pop;
    logic               cfg_wr;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIDTH:  prdata = APB_DW'(r_width);
            REG_HEIGHT: prdata = APB_DW'(r_height);
            default:    prdata = '0;
        endcase
    end

    // effective last column / row, sizes clamped to [3, MAX]
    always_comb begin
        w_ext = DCW'(r_width);
        h_ext = DRW'(r_height);
        if (w_ext < DCW'(3))
            col_last = CW'(2);
        else if (w_ext > DCW'(MAX_COLS))
            col_last = CW'(MAX_COLS - 1);
        else
            col_last = CW'(w_ext - DCW'(1));
        if (h_ext < DRW'(3))
            row_last = RW'(2);
        else if (h_ext > DRW'(MAX_ROWS))
            row_last = RW'(MAX_ROWS - 1);
        else
            row_last = RW'(h_ext - DRW'(1));
    end

    // ---------------- position ----------------
    assign acc      = s_axis_tvalid && s_axis_tready;
    assign last_col = (r_col >= col_last);
    assign last_row = (r_row >= row_last);
    assign row0     = (r_row == '0);
    assign row1     = (r_row == RW'(1));
    assign border   = (r_col == '0) || last_col;

    assign col_next   = last_col ? '0 : r_col + CW'(1);
    // next column's right neighbour; out of range only where it is unused
    assign newer_addr = col_next + CW'(1);

    always_comb begin
        if (!last_col)
            row_next = r_row;
        else if (last_row)
            row_next = '0;
        else
            row_next = r_row + RW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= col_next;
            r_row <= row_next;
        end
    end

    // ---------------- line memories ----------------
    // Write column c, read one column ahead. w >= 3 keeps the read and
    // write addresses apart, including at the row wrap.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            mem_older[r_col] <= r_up1;
            mem_newer[r_col] <= s_axis_tdata;
            r_up2            <= mem_older[col_next];
            r_right          <= mem_newer[newer_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_left <= r_up1;
            r_up1  <= last_col ? r_first : r_right;
            if (r_col == '0)
                r_first <= s_axis_tdata;
        end
    end

    // ---------------- filter ----------------
    assign sum = {2'b00, r_up2} + {2'b00, s_axis_tdata}
               + {2'b00, r_left} + {2'b00, r_right};
    assign out_pix = border ? r_up1 : sum[PIX_W+1:2];

    always_comb begin
        ent1.pix  = s_axis_tdata;
        ent1.eof  = last_col;
        ent1.last = 1'b1;
        if (row0) begin
            ent0.pix  = s_axis_tdata;
            ent0.eof  = 1'b0;
            ent0.last = 1'b1;
            push_n    = 2'd1;
        end else if (row1) begin
            ent0.pix  = out_pix;
            ent0.eof  = 1'b0;
            ent0.last = 1'b1;
            push_n    = 2'd0;
        end else begin
            ent0.pix  = out_pix;
            ent0.eof  = 1'b0;
            ent0.last = !last_row;
            push_n    = last_row ? 2'd2 : 2'd1;
        end
    end

    // ---------------- output queue ----------------
    assign s_axis_tready = (r_count <= FC_W'(FIFO_DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_fifo[r_rd].pix;
    assign m_axis_tlast  = r_fifo[r_rd].eof;
    assign m_axis_tuser  = r_fifo[r_rd].last;

    always_comb begin
        n_count = r_count;
        if (acc)
            n_count = n_count + FC_W'(push_n);
        if (pop)
            n_count = n_count - FC_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (acc && push_n != 2'd0)
            r_fifo[r_wr] <= ent0;
        if (acc && push_n == 2'd2)
            r_fifo[r_wr + FP_W'(1)] <= ent1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (acc)
                r_wr <= r_wr + FP_W'(push_n);
            if (pop)
                r_rd <= r_rd + FP_W'(1);
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    // queue never overfills
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FC_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // column advances by one inside a row
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && !last_col) |=> (r_col == $past(r_col) + CW'(1)))
        else $error("column counter did not advance");

    // queue level moves only on a handshake
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!acc && !pop) |=> $stable(r_count))
        else $error("queue level changed without handshake");

    // a push of two results on the last column restarts position at row 0, column 0
    a_eof_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && push_n == 2'd2 && last_col) |=> (r_col == '0 && r_row == '0))
        else $error("frame end did not restart position");
`endif

endmodule

`default_nettype wire
